@@ rtl/core/dgr_pkg.sv @@
`timescale 1ns / 1ps

package dgr_pkg;

    // field widths
    localparam int unsigned IeeeW   = 64;
    localparam int unsigned BexpW   = 11;
    localparam int unsigned MantW   = 52;
    localparam int unsigned SigW    = MantW + 1;
    localparam int unsigned HexpW   = 7;
    localparam int unsigned GfracW  = 56;
    localparam int unsigned QuartW  = 10;

    // smallest magnitude pattern that is not flushed to zero (double nearest 1e-77)
    localparam logic [IeeeW-2:0] TINY_LIMIT = 63'h2FF286D80EC190DC;

    // all-ones binary exponent marks infinity or nan
    localparam logic [BexpW-1:0] BEXP_SPECIAL = 11'h7FF;

    // (bexp + 1) / 4 bounds for hex exponents -64 and 63
    localparam logic [QuartW-1:0] QUART_MIN = 10'd191;
    localparam logic [QuartW-1:0] QUART_MAX = 10'd318;

    // item class decided by the front end
    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_NUM  = 2'd1,
        CLS_ERR  = 2'd2
    } dgr_cls_t;

    // classified item carried from front to back
    typedef struct packed {
        dgr_cls_t          cls;
        logic              sign;
        logic [HexpW-1:0]  hexp;
        logic [1:0]        shift;
        logic [MantW-1:0]  mant;
    } dgr_item_t;

endpackage

@@ rtl/core/dgr_front.sv @@
`timescale 1ns / 1ps

module dgr_front
    import dgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [IeeeW-1:0]  in_bits,
    output logic              out_valid,
    input  logic              out_ready,
    output dgr_item_t         out_item
);

    logic                valid_reg;
    logic                valid_next;
    dgr_item_t           item_reg;
    dgr_item_t           item_next;
    logic [BexpW-1:0]    bexp;
    logic [BexpW:0]      e1;
    logic [QuartW-1:0]   quart;
    logic [QuartW-1:0]   hexp_wide;
    logic                is_tiny;

    // unpack and estimate the hex exponent
    always_comb
    begin
        bexp      = in_bits[IeeeW-2 -: BexpW];
        e1        = {1'b0, bexp} + {{BexpW{1'b0}}, 1'b1};
        quart     = e1[BexpW:2];
        hexp_wide = quart - QUART_MIN;
        is_tiny   = in_bits[IeeeW-2:0] < TINY_LIMIT;
    end

    // classify
    always_comb
    begin
        item_next.sign  = in_bits[IeeeW-1];
        item_next.hexp  = hexp_wide[HexpW-1:0];
        item_next.shift = e1[1:0];
        item_next.mant  = in_bits[MantW-1:0];
        if (bexp == BEXP_SPECIAL)
        begin
            item_next.cls = CLS_ERR;
        end
        else if (is_tiny)
        begin
            item_next.cls = CLS_ZERO;
        end
        else if ((quart > QUART_MAX) || (quart < QUART_MIN))
        begin
            item_next.cls = CLS_ERR;
        end
        else
        begin
            item_next.cls = CLS_NUM;
        end
    end

    // one register stage toward the queue
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_valid || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/core/dgr_queue.sv @@
`timescale 1ns / 1ps

module dgr_queue
    import dgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dgr_item_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output dgr_item_t  out_item,
    output logic       full
);

    dgr_item_t   slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    // two-entry fifo between front and back
    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign out_item = slot_reg[rd_ptr_reg];

endmodule

@@ rtl/core/dgr_back.sv @@
`timescale 1ns / 1ps

module dgr_back
    import dgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dgr_item_t         in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IeeeW-1:0]  out_word,
    output logic              out_err
);

    logic              valid_reg;
    logic [IeeeW-1:0]  word_reg;
    logic [IeeeW-1:0]  word_next;
    logic              err_reg;
    logic              err_next;
    logic [GfracW-1:0] frac;

    // align significand by 0 to 3 bits and repack
    always_comb
    begin
        frac = {{(GfracW - SigW){1'b0}}, 1'b1, in_item.mant} << in_item.shift;
        word_next = '0;
        err_next  = 1'b0;
        case (in_item.cls)
            CLS_NUM:
            begin
                word_next = {in_item.sign, in_item.hexp, frac};
            end
            CLS_ERR:
            begin
                err_next = 1'b1;
            end
            default:
            begin
                word_next = '0;
            end
        endcase
    end

    // output register
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_err   = err_reg;

endmodule

@@ rtl/core/ieee_double_to_gdsii_real_unit.sv @@
`timescale 1ns / 1ps

// Converts the raw bit pattern of an IEEE 754 double into an 8-byte GDSII real
// (sign, 7-bit excess-64 base-16 exponent, 56-bit fraction in [1/16,1)). The
// conversion is exact: the significand is only shifted left by 0 to 3 bits.
// Magnitudes below 1e-77, signed zero and subnormals give an all-zero word;
// infinity, NaN or a hex exponent outside -64..63 give a zero word with the
// error flag (tuser) set. One item is accepted per cycle while s_axis_tready is high;
// each item passes through the classify register, the two-entry queue and the
// output register in that order, and the front end keeps accepting while the
// output stalls until the queue is full.

module ieee_double_to_gdsii_real_unit
    import dgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IeeeW-1:0]  s_axis_tdata,   // ieee_bits
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [IeeeW-1:0]  m_axis_tdata,   // gdsii_word
    output logic [0:0]        m_axis_tuser    // range_error
);

    logic       f_valid;
    logic       f_ready;
    dgr_item_t  f_item;
    logic       q_valid;
    logic       q_ready;
    dgr_item_t  q_item;
    logic       q_full;
    logic       b_err;

    // classify front end
    dgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_bits   (s_axis_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    // decoupling queue
    dgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item),
        .full      (q_full)
    );

    // pack back end
    dgr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_err   (b_err)
    );

    assign m_axis_tuser = b_err;

`ifndef SYNTHESIS
    // an error result always carries a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("error result with nonzero word");

    // a nonzero word has a normalized fraction
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata != '0)) |-> (m_axis_tdata[55:52] != 4'd0))
    else $error("fraction not normalized");

    // a full queue means the back end is stalled by the output
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> (m_axis_tvalid && $past(m_axis_tvalid)))
    else $error("queue full while output idle");
`endif

endmodule
